// File: rtl/opus_packet_frame_parser_macros.svh
// assertion macros for the opus packet frame parser
// no dependencies
`ifndef OPUS_PACKET_FRAME_PARSER_MACROS_SVH
`define OPUS_PACKET_FRAME_PARSER_MACROS_SVH
`ifndef SYNTH
`define OPF_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define OPF_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define OPF_ASSERT_IMPL(label, clk, rst, a, c)
`define OPF_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/opf_pkg.sv
// types, constants and helpers shared by the opus packet frame parser
// no dependencies
`default_nettype none
package opf_pkg;
   localparam int MaxFrames = 48;
   localparam logic [15:0] MaxPacketBytes = 16'd65535;
   localparam logic [10:0] FrameCap = 11'd1275;
   localparam logic [12:0] SampleCap = 13'd5760;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusEmpty = 2'd1;
   localparam logic [1:0] StatusBad = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  toc_config;
      logic        stereo;
      logic [11:0] frame_samples;
      logic [5:0]  frame_total;
      logic [5:0]  frame_index;
      logic [15:0] frame_offset;
      logic [10:0] frame_length;
      logic        last;
   } rsp_type;

   // divider request and answer
   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [5:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
      logic [5:0]  remainder;
   } div_rsp_type;

   // samples per frame from the toc byte
   function automatic logic [11:0] samples_of(input logic [7:0] toc);
      logic [4:0] c;
      c = toc[7:3];
      if (c >= 5'd16) return 12'(12'd120 << c[1:0]);
      if (c < 5'd12) begin
         case (c[1:0])
            2'd0: return 12'd480;
            2'd1: return 12'd960;
            2'd2: return 12'd1920;
            default: return 12'd2880;
         endcase
      end
      return 12'(12'd480 << c[0]);
   endfunction
endpackage
`default_nettype wire

// File: rtl/opf_divider.sv
// restoring divider, one quotient bit per cycle
// depends on opf_pkg
`default_nettype none
module opf_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire opf_pkg::div_req_type div_req,
   output opf_pkg::div_rsp_type      div_rsp
);
   logic [15:0] quo_ff, quo_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  trial;

   // one shift and subtract step
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[15]};
      if (div_req.start) begin
         quo_in = div_req.dividend; rem_in = '0; dvs_in = div_req.divisor;
         cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 6'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[5:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.remainder = rem_ff;
endmodule
`default_nettype wire

// File: rtl/opus_packet_frame_parser.sv
// Opus packet frame parser: one packet byte per item, descriptors at packet end.
// Other items are taken when idle; an end waits while an earlier error item is unread.
// A packet end then runs the checks; an empty packet or one found malformed goes to the hold,
// else a CBR count divide, then one descriptor per emit step unless stalled, and a hold to clear.
// Reset (synchronous, active high) clears the parse state; the size table is
// left unset and only read after it is written within the same packet.
`default_nettype none
`include "opus_packet_frame_parser_macros.svh"
module opus_packet_frame_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire opf_pkg::req_type req_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output opf_pkg::rsp_type      rsp_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready
);
   localparam logic [3:0] PhToc = 4'd0, PhSizeA = 4'd1, PhSizeB = 4'd2,
      PhCount = 4'd3, PhPad = 4'd4, PhPayload = 4'd5, PhSkip = 4'd6;

   typedef enum logic [2:0] {
      StIdle, StCheck, StDivWait, StDivDone, StEmit, StHold
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  toc_ff, toc_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] pad_ff, pad_in;
   logic [7:0]  low_ff, low_in;
   logic [5:0]  parsed_ff, parsed_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] hlen_ff, hlen_in;
   logic        err_ff, err_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] lastlen_ff, lastlen_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        tab_ff, tab_in;
   logic [5:0]  idx_ff, idx_in;
   logic [15:0] off_ff, off_in;
   opf_pkg::rsp_type rsp_ff, rsp_in;
   logic        rv_ff, rv_in;
   logic [10:0] table_mem [opf_pkg::MaxFrames];
   logic [10:0] tab_rd_ff;
   logic        tab_we;
   logic [5:0]  tab_wa;
   logic [10:0] tab_wd;
   opf_pkg::div_req_type div_req;
   opf_pkg::div_rsp_type div_rsp;

   opf_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic        acc;
   logic [7:0]  b;
   logic [16:0] padsum;
   logic [10:0] sz;
   logic        szdone;
   logic [17:0] smul;
   logic [10:0] cur_len;
   logic        rsp_ok;

   assign req_ready = (state_ff == StIdle);
   assign acc = req_valid && req_ready;
   assign b = req_data.data_byte;

   // size table, read address is the next frame index
   always_ff @(posedge clock) begin
      if (tab_we) table_mem[tab_wa] <= tab_wd;
      tab_rd_ff <= table_mem[idx_in];
   end

   always_comb begin
      state_in = state_ff; toc_in = toc_ff; bytes_in = bytes_ff; phase_in = phase_ff;
      flags_in = flags_ff; pad_in = pad_ff; low_in = low_ff; parsed_in = parsed_ff;
      sum_in = sum_ff; hlen_in = hlen_ff; err_in = err_ff; rem_in = rem_ff;
      base_in = base_ff; lastlen_in = lastlen_ff; cnt_in = cnt_ff; tab_in = tab_ff;
      idx_in = idx_ff; off_in = off_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      tab_we = 1'b0; tab_wa = parsed_ff; tab_wd = '0;
      div_req = '0; div_req.dividend = rem_ff; div_req.divisor = cnt_ff;
      padsum = 17'(pad_ff) + 17'((b == 8'd255) ? 8'd254 : b);
      sz = 11'(b); szdone = 1'b0;
      smul = 18'(opf_pkg::samples_of(toc_ff)) * 18'(b[5:0]);
      cur_len = (idx_ff + 6'd1 == cnt_ff) ? lastlen_ff[10:0]
                : (tab_ff ? tab_rd_ff : base_ff[10:0]);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (acc && req_data.has_byte) begin
               if (bytes_ff >= opf_pkg::MaxPacketBytes) begin
                  err_in = 1'b1; phase_in = PhSkip;
               end else begin
                  bytes_in = bytes_ff + 16'd1;
                  // header parse of one byte
                  case (phase_ff)
                     PhToc: begin
                        toc_in = b;
                        if (b[1:0] == 2'd2) phase_in = PhSizeA;
                        else if (b[1:0] == 2'd3) phase_in = PhCount;
                        else begin hlen_in = bytes_in; phase_in = PhPayload; end
                     end
                     PhSizeA: begin
                        if (b < 8'd252) szdone = 1'b1;
                        else begin low_in = b; phase_in = PhSizeB; end
                     end
                     PhSizeB: begin
                        sz = 11'({b, 2'b00}) + 11'(low_ff); szdone = 1'b1;
                     end
                     PhCount: begin
                        flags_in = b;
                        if (b[5:0] == 6'd0 || b[5:0] > 6'(opf_pkg::MaxFrames)
                            || smul > 18'(opf_pkg::SampleCap)) begin
                           err_in = 1'b1; phase_in = PhSkip;
                        end else if (b[6]) phase_in = PhPad;
                        else if (b[7] && b[5:0] > 6'd1) phase_in = PhSizeA;
                        else begin hlen_in = bytes_in; phase_in = PhPayload; end
                     end
                     PhPad: begin
                        pad_in = padsum[16] ? 16'hFFFF : padsum[15:0];
                        if (b != 8'd255) begin
                           if (flags_ff[7] && flags_ff[5:0] > 6'd1) phase_in = PhSizeA;
                           else begin hlen_in = bytes_in; phase_in = PhPayload; end
                        end
                     end
                     default: ;
                  endcase
                  if (szdone) begin
                     tab_we = (parsed_ff < 6'(opf_pkg::MaxFrames));
                     tab_wd = sz;
                     parsed_in = parsed_ff + 6'd1;
                     sum_in = sum_ff + 16'(sz);
                     if (toc_ff[1:0] == 2'd2 || parsed_in + 6'd1 >= flags_ff[5:0]) begin
                        hlen_in = bytes_in; phase_in = PhPayload;
                     end else phase_in = PhSizeA;
                  end
               end
            end
            if (acc && req_data.packet_end) state_in = StCheck;
         end
         StCheck: begin
            // wait until an earlier error item has been taken
            if (!rv_ff) begin
               rsp_in = '0; rsp_in.last = 1'b1;
               rsp_in.toc_config = toc_ff[7:3]; rsp_in.stereo = toc_ff[2];
               rsp_in.frame_samples = opf_pkg::samples_of(toc_ff);
               tab_in = 1'b0; base_in = '0; lastlen_in = '0; idx_in = '0; off_in = hlen_ff;
               if (!err_ff && bytes_ff == 16'd0) begin
                  rsp_in = '0; rsp_in.status = opf_pkg::StatusEmpty; rsp_in.last = 1'b1;
                  state_in = StHold;
               end else if (err_ff || phase_ff != PhPayload || hlen_ff > bytes_ff) begin
                  rsp_in = '0; rsp_in.status = opf_pkg::StatusBad; rsp_in.last = 1'b1;
                  state_in = StHold;
               end else begin
                  rem_in = bytes_ff - hlen_ff;
                  state_in = StDivDone;
                  case (toc_ff[1:0])
                     2'd0: begin cnt_in = 6'd1; base_in = rem_in; lastlen_in = rem_in; end
                     2'd1: begin
                        cnt_in = 6'd2; base_in = {1'b0, rem_in[15:1]}; lastlen_in = base_in;
                        if (rem_in[0]) state_in = StHold;
                     end
                     2'd2: begin
                        cnt_in = 6'd2; tab_in = 1'b1;
                        if (sum_ff > rem_in) state_in = StHold;
                        else lastlen_in = rem_in - sum_ff;
                     end
                     default: begin
                        cnt_in = flags_ff[5:0];
                        if (pad_ff > rem_in) state_in = StHold;
                        else begin
                           rem_in = rem_in - pad_ff;
                           if (flags_ff[7] && cnt_in > 6'd1) begin
                              tab_in = 1'b1;
                              if (sum_ff > rem_in) state_in = StHold;
                              else lastlen_in = rem_in - sum_ff;
                           end else state_in = StDivWait;
                        end
                     end
                  endcase
                  if (state_in == StHold) begin
                     rsp_in = '0; rsp_in.status = opf_pkg::StatusBad; rsp_in.last = 1'b1;
                  end
               end
            end
         end
         StDivWait: begin
            // start the divide on entry, then wait for the quotient
            if (lastlen_ff != 16'hFFFF) begin
               div_req.start = 1'b1; lastlen_in = 16'hFFFF;
            end else if (div_rsp.done) begin
               base_in = div_rsp.quotient; lastlen_in = div_rsp.quotient;
               if (div_rsp.remainder != 6'd0) begin
                  rsp_in = '0; rsp_in.status = opf_pkg::StatusBad; rsp_in.last = 1'b1;
                  state_in = StHold;
               end else state_in = StDivDone;
            end
         end
         StDivDone: begin
            if (lastlen_ff > 16'(opf_pkg::FrameCap) || base_ff > 16'(opf_pkg::FrameCap)) begin
               rsp_in = '0; rsp_in.status = opf_pkg::StatusBad; rsp_in.last = 1'b1;
               state_in = StHold;
            end else state_in = StEmit;
         end
         StEmit: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in.status = opf_pkg::StatusOk;
               rsp_in.frame_total = cnt_ff; rsp_in.frame_index = idx_ff;
               rsp_in.frame_offset = off_ff; rsp_in.frame_length = cur_len;
               rsp_in.last = (idx_ff + 6'd1 == cnt_ff);
               rv_in = 1'b1;
               off_in = off_ff + 16'(cur_len);
               idx_in = idx_ff + 6'd1;
               if (rsp_in.last) state_in = StHold;
            end
         end
         default: begin
            // hold: raise an error item or let the last descriptor go, then clear
            if (!rv_ff || rsp_ready) begin
               if (rsp_ff.status != opf_pkg::StatusOk) rv_in = 1'b1;
               state_in = StIdle;
               toc_in = '0; bytes_in = '0; phase_in = PhToc; flags_in = '0;
               pad_in = '0; low_in = '0; parsed_in = '0; sum_in = '0;
               hlen_in = '0; err_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; toc_ff <= '0; bytes_ff <= '0; phase_ff <= PhToc;
         flags_ff <= '0; pad_ff <= '0; low_ff <= '0; parsed_ff <= '0;
         sum_ff <= '0; hlen_ff <= '0; err_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; toc_ff <= toc_in; bytes_ff <= bytes_in;
         phase_ff <= phase_in; flags_ff <= flags_in; pad_ff <= pad_in;
         low_ff <= low_in; parsed_ff <= parsed_in; sum_ff <= sum_in;
         hlen_ff <= hlen_in; err_ff <= err_in; rv_ff <= rv_in;
      end
      rem_ff <= rem_in; base_ff <= base_in; lastlen_ff <= lastlen_in;
      cnt_ff <= cnt_in; tab_ff <= tab_in; idx_ff <= idx_in; off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rv_ff;
   assign rsp_ok = rsp_valid && rsp_data.status == opf_pkg::StatusOk;

   `OPF_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == StIdle)
   `OPF_ASSERT_IMPL(a_err_last, clock, reset, rsp_valid && !rsp_ok, rsp_data.last)
   `OPF_ASSERT_IMPL(a_idx_cnt, clock, reset, rsp_ok, rsp_data.frame_index < rsp_data.frame_total)
   `OPF_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule
`default_nettype wire

// File: bench/opus_packet_frame_parser_test.sv
// testbench for the opus packet frame parser: directed table, then random packets
// depends on opf_pkg and opus_packet_frame_parser
`timescale 1ns / 1ps
module opus_packet_frame_parser_test;
   localparam int CycleLimit = 2000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   opf_pkg::req_type req_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             rsp_ready = 1'b0;
   opf_pkg::rsp_type rsp_data;
   logic             rsp_valid;

   opus_packet_frame_parser uut (
      .clock(clock), .reset(reset),
      .req_data(req_data), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parse state of the predictor
   typedef enum logic [2:0] {
      PhToc, PhSizeA, PhSizeB, PhCount, PhPad, PhPayload, PhSkip
   } phase_type;

   logic [7:0]  p_toc;
   logic [16:0] p_bytes;
   phase_type   p_phase;
   logic [7:0]  p_count_byte;
   logic [16:0] p_pad;
   logic [7:0]  p_size_low;
   logic [6:0]  p_sizes_done;
   logic [16:0] p_sizes_sum;
   logic [16:0] p_header_len;
   logic [10:0] p_size_table [opf_pkg::MaxFrames];
   logic        p_error;

   opf_pkg::rsp_type frame_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 28;
   int      recv_idle_pct = 67;
   bit      hold_off = 1'b0;

   function automatic logic [11:0] toc_samples(input logic [7:0] toc);
      logic [4:0] c;
      c = toc[7:3];
      if (c >= 16) return 12'(120 << c[1:0]);
      if (c < 12) return (c[1:0] == 0) ? 12'd480 : (c[1:0] == 1) ? 12'd960 :
                         (c[1:0] == 2) ? 12'd1920 : 12'd2880;
      return 12'(480 << c[0]);
   endfunction

   task automatic clear_parse();
      p_toc = 0; p_bytes = 0; p_phase = PhToc; p_count_byte = 0; p_pad = 0;
      p_size_low = 0; p_sizes_done = 0; p_sizes_sum = 0; p_header_len = 0;
      p_error = 0;
   endtask

   task automatic begin_payload();
      p_header_len = p_bytes;
      p_phase = PhPayload;
   endtask

   task automatic after_padding();
      if (p_count_byte[7] && p_count_byte[5:0] > 1) p_phase = PhSizeA;
      else begin_payload();
   endtask

   task automatic size_parsed(input int size);
      if (p_sizes_done < opf_pkg::MaxFrames) p_size_table[p_sizes_done] = 11'(size);
      p_sizes_done++;
      p_sizes_sum = 17'(p_sizes_sum + size);
      if (p_toc[1:0] == 2 || p_sizes_done + 1 >= p_count_byte[5:0]) begin_payload();
      else p_phase = PhSizeA;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      int n, s;
      case (p_phase)
         PhToc: begin
            p_toc = b;
            if (b[1:0] == 2) p_phase = PhSizeA;
            else if (b[1:0] == 3) p_phase = PhCount;
            else begin_payload();
         end
         PhSizeA: begin
            if (b < 252) size_parsed(b);
            else begin
               p_size_low = b;
               p_phase = PhSizeB;
            end
         end
         PhSizeB: size_parsed(4 * b + p_size_low);
         PhCount: begin
            n = b[5:0];
            p_count_byte = b;
            if (n == 0 || n > opf_pkg::MaxFrames || toc_samples(p_toc) * n > 5760) begin
               p_error = 1; p_phase = PhSkip;
            end else if (b[6]) p_phase = PhPad;
            else after_padding();
         end
         PhPad: begin
            s = p_pad + ((b == 255) ? 254 : b);
            p_pad = (s > 65535) ? 17'd65535 : 17'(s);
            if (b != 255) after_padding();
         end
         default: ;
      endcase
   endtask

   function automatic opf_pkg::rsp_type bad_frame(input logic [1:0] st);
      opf_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   // descriptors for the packet just ended
   task automatic close_packet();
      int rem, n, base, last_len, off, len;
      bit bad, use_table;
      opf_pkg::rsp_type r;
      base = 0; last_len = 0; bad = 0; n = 0;
      if (!p_error && p_bytes == 0) begin
         frame_queue.push_back(bad_frame(opf_pkg::StatusEmpty));
         return;
      end
      if (p_error || p_phase != PhPayload || p_header_len > p_bytes) begin
         frame_queue.push_back(bad_frame(opf_pkg::StatusBad));
         return;
      end
      rem = p_bytes - p_header_len;
      case (p_toc[1:0])
         2'd0: begin n = 1; base = rem; last_len = rem; end
         2'd1: begin n = 2; bad = rem[0]; base = rem / 2; last_len = base; end
         2'd2: begin
            n = 2; bad = p_sizes_sum > rem;
            if (!bad) last_len = rem - p_sizes_sum;
         end
         default: begin
            n = p_count_byte[5:0];
            if (n == 0 || n > opf_pkg::MaxFrames || p_pad > rem) bad = 1;
            else begin
               rem -= p_pad;
               if (p_count_byte[7] && n > 1) begin
                  bad = p_sizes_sum > rem;
                  if (!bad) last_len = rem - p_sizes_sum;
               end else begin
                  bad = (rem % n) != 0;
                  base = rem / n; last_len = base;
               end
            end
         end
      endcase
      if (bad || last_len > 1275 || base > 1275) begin
         frame_queue.push_back(bad_frame(opf_pkg::StatusBad));
         return;
      end
      use_table = p_toc[1:0] == 2 || (p_toc[1:0] == 3 && p_count_byte[7] && n > 1);
      off = p_header_len;
      for (int i = 0; i < n; i++) begin
         if (i + 1 == n) len = last_len;
         else if (use_table) len = p_size_table[i];
         else len = base;
         r.status = opf_pkg::StatusOk;
         r.toc_config = p_toc[7:3];
         r.stereo = p_toc[2];
         r.frame_samples = toc_samples(p_toc);
         r.frame_total = 6'(n);
         r.frame_index = 6'(i);
         r.frame_offset = 16'(off);
         r.frame_length = 11'(len);
         r.last = (i + 1 == n);
         frame_queue.push_back(r);
         off += len;
      end
   endtask

   task automatic predict_item(input opf_pkg::req_type it);
      if (it.has_byte) begin
         if (p_bytes >= opf_pkg::MaxPacketBytes) begin
            p_error = 1; p_phase = PhSkip;
         end else begin
            p_bytes++;
            parse_byte(it.data_byte);
         end
      end
      if (it.packet_end) begin
         close_packet();
         clear_parse();
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // sending one item, with idling before it
   task automatic send_item(input logic [7:0] b, input bit has, input bit fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{data_byte: b, has_byte: has, packet_end: fin};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item('{data_byte: b, has_byte: has, packet_end: fin});
   endtask

   task automatic finish_send();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_frames();
      finish_send();
      while (frame_queue.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // a packet from a byte list, with the end on the last byte
   task automatic send_packet(input logic [7:0] bytes[$]);
      foreach (bytes[i]) send_item(bytes[i], 1'b1, i == bytes.size() - 1);
   endtask

   // random well-formed header with random payload, sometimes broken
   task automatic random_packet();
      logic [7:0] bytes[$];
      int code, n, payload, frames_max;
      logic [7:0] toc, cb;
      code = $urandom_range(3);
      toc = {5'($urandom), 1'($urandom), 2'(code)};
      bytes.push_back(toc);
      payload = $urandom_range(0, 10);
      if (code == 2) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(252, 300) : $urandom_range(0, 12);
         if (n < 252) bytes.push_back(8'(n));
         else begin
            bytes.push_back(8'(252 + n % 4)); bytes.push_back(8'((n - 252) / 4));
         end
         payload = (n < 252) ? n + $urandom_range(0, 6) : $urandom_range(0, 8);
      end else if (code == 3) begin
         frames_max = 5760 / toc_samples(toc);
         if (frames_max > 48) frames_max = 48;
         n = $urandom_range(1, frames_max > 6 ? 6 : frames_max);
         if ($urandom_range(9) == 0) n = $urandom_range(0, 63);
         cb = {1'($urandom), 1'($urandom_range(3) == 0), 6'(n)};
         bytes.push_back(cb);
         if (cb[6]) begin
            if ($urandom_range(3) == 0) bytes.push_back(8'd255);
            bytes.push_back(8'($urandom_range(0, 6)));
         end
         if (cb[7]) for (int i = 1; i < n && i < 48; i++)
            bytes.push_back($urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8)));
         payload = cb[7] ? $urandom_range(0, 12) : n * $urandom_range(0, 2);
         if (cb[6]) payload += 3;
      end else if (code == 1) payload = 2 * $urandom_range(0, 5);
      if ($urandom_range(9) == 0) payload = $urandom_range(0, 3);
      repeat (payload) bytes.push_back(8'($urandom));
      if ($urandom_range(15) == 0) begin
         foreach (bytes[i]) send_item(bytes[i], 1'b1, 1'b0);
         send_item(8'($urandom), 1'b0, 1'b1);
      end else send_packet(bytes);
   endtask

   // result side: random stall, long hold-off when asked
   always @(negedge clock) begin
      if (!reset) rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_queue.size() == 0) report_mismatch("unexpected item", 0, 0);
         else begin
            opf_pkg::rsp_type w;
            w = frame_queue.pop_front();
            if (rsp_data.status !== w.status) report_mismatch("status", rsp_data.status, w.status);
            if (rsp_data.toc_config !== w.toc_config)
               report_mismatch("toc_config", rsp_data.toc_config, w.toc_config);
            if (rsp_data.stereo !== w.stereo) report_mismatch("stereo", rsp_data.stereo, w.stereo);
            if (rsp_data.frame_samples !== w.frame_samples)
               report_mismatch("frame_samples", rsp_data.frame_samples, w.frame_samples);
            if (rsp_data.frame_total !== w.frame_total)
               report_mismatch("frame_total", rsp_data.frame_total, w.frame_total);
            if (rsp_data.frame_index !== w.frame_index)
               report_mismatch("frame_index", rsp_data.frame_index, w.frame_index);
            if (rsp_data.frame_offset !== w.frame_offset)
               report_mismatch("frame_offset", rsp_data.frame_offset, w.frame_offset);
            if (rsp_data.frame_length !== w.frame_length)
               report_mismatch("frame_length", rsp_data.frame_length, w.frame_length);
            if (rsp_data.last !== w.last) report_mismatch("last", rsp_data.last, w.last);
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[opus_packet_frame_parser] ERROR");
         $finish;
      end
   end

   // directed rows: byte, has_byte, packet_end, typed status check where obvious
   typedef struct {
      logic [7:0] b;
      bit has;
      bit fin;
      bit typed;
      logic [1:0] st;
   } row_type;

   row_type rows[] = '{
      '{8'h00, 0, 1, 1, opf_pkg::StatusEmpty},   // empty packet
      '{8'h00, 0, 0, 0, opf_pkg::StatusOk},      // idle item, ignored
      '{8'hFC, 1, 1, 0, opf_pkg::StatusOk},      // code 0, zero-length frame
      '{8'h01, 1, 1, 0, opf_pkg::StatusOk},      // code 1, two empty frames
      '{8'h01, 1, 0, 0, opf_pkg::StatusOk},      // code 1, odd payload
      '{8'hAB, 1, 1, 1, opf_pkg::StatusBad},
      '{8'h02, 1, 1, 1, opf_pkg::StatusBad},     // truncated length code
      '{8'h7E, 1, 0, 0, opf_pkg::StatusOk},      // code 2, two-byte length truncated
      '{8'hFF, 1, 1, 1, opf_pkg::StatusBad},
      '{8'h03, 1, 1, 1, opf_pkg::StatusBad},     // missing count byte
      '{8'h03, 1, 0, 0, opf_pkg::StatusOk},      // count zero
      '{8'h00, 1, 1, 1, opf_pkg::StatusBad},
      '{8'hFB, 1, 0, 0, opf_pkg::StatusOk},      // count 49
      '{8'h31, 1, 1, 1, opf_pkg::StatusBad},
      '{8'h1B, 1, 0, 0, opf_pkg::StatusOk},      // 60 ms x 3 exceeds samples
      '{8'h03, 1, 1, 1, opf_pkg::StatusBad},
      '{8'h83, 1, 0, 0, opf_pkg::StatusOk},      // 48 frames of 2.5 ms, cbr empty
      '{8'h30, 1, 1, 0, opf_pkg::StatusOk},
      '{8'hFB, 1, 0, 0, opf_pkg::StatusOk},      // padding chain truncated
      '{8'h42, 1, 0, 0, opf_pkg::StatusOk},
      '{8'hFF, 1, 1, 1, opf_pkg::StatusBad},
      '{8'h07, 1, 0, 0, opf_pkg::StatusOk},      // vbr, 2 frames, one size
      '{8'h82, 1, 0, 0, opf_pkg::StatusOk},
      '{8'h01, 1, 0, 0, opf_pkg::StatusOk},
      '{8'h55, 1, 0, 0, opf_pkg::StatusOk},
      '{8'h00, 0, 1, 0, opf_pkg::StatusOk}       // end without byte
   };

   initial begin
      clear_parse();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            finish_send();
            while (frame_queue.size() != 0) @(negedge clock);
         end
         send_item(rows[i].b, rows[i].has, rows[i].fin);
         if (rows[i].typed && rows[i].fin) begin
            if (frame_queue.size() != 1 || frame_queue[0].status != rows[i].st)
               report_mismatch("directed status", frame_queue.size(), rows[i].st);
         end
      end
      drain_frames();

      // random phases with the three idle settings
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
         recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 28 : 0;
         for (int k = 0; k < 8; k++) random_packet();
         if (ph == 0) begin
            // long receiver hold-off while packets keep coming
            hold_off = 1'b1;
            fork
               begin repeat (3000) @(negedge clock); hold_off = 1'b0; end
               for (int k = 0; k < 4; k++) random_packet();
            join
         end
         // sender waits until every expected item has arrived
         drain_frames();
      end
      recv_idle_pct = 0;
      drain_frames();
      repeat (100) @(negedge clock);
      if (error_count == 0 && frame_queue.size() == 0)
         $display("[opus_packet_frame_parser] OK");
      else
         $display("[opus_packet_frame_parser] ERROR");
      $finish;
   end
endmodule
